// ===== rtl/pcc_pkg.sv =====
// Shared types, constants, microcode table and saturation helper for the clamped PID core.
`default_nettype none

package pcc_pkg;

    localparam int DATA_W = 32;
    localparam int STEP_W = 24;
    localparam int FRAC_W = 16;
    localparam int DVD_W  = DATA_W + 1 + FRAC_W;   // |error delta| scaled by 2^16
    localparam int CNT_W  = 6;
    localparam int SUM_W  = 52;
    localparam int PROD_W = 64;
    localparam int PC_W   = 4;
    localparam int ADDR_W = 3;

    localparam logic signed [SUM_W-1:0] S32_MAX_W = 52'sd2147483647;
    localparam logic signed [SUM_W-1:0] S32_MIN_W = -52'sd2147483648;

    localparam logic signed [DATA_W-1:0] UPPER_RST = 32'sd65536;
    localparam logic signed [DATA_W-1:0] LOWER_RST = -32'sd65536;

    typedef enum logic [ADDR_W-1:0] {
        REG_GAIN_PROP  = 3'd0,
        REG_GAIN_INTEG = 3'd1,
        REG_GAIN_DERIV = 3'd2,
        REG_OUT_UPPER  = 3'd3,
        REG_OUT_LOWER  = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_INTEG,
        OP_CLAMP,
        OP_SUM_LD,
        OP_SUM_ADD,
        OP_DERIV,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_ERR_STEP,
        MUL_KP,
        MUL_KI,
        MUL_KD
    } t_mul_sel;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_IN_WAIT,
        JC_DIV_WAIT,
        JC_OUT_WAIT,
        JC_ALWAYS
    } t_jcond;

    typedef struct packed {
        t_op             op;
        t_mul_sel        mul;
        logic            div_start;
        t_jcond          jc;
        logic [PC_W-1:0] target;
    } t_cword;

    // control word handed to the datapath, qualified by exec
    typedef struct packed {
        t_op      op;
        t_mul_sel mul;
        logic     div_start;
        logic     exec;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic div_busy;
        logic out_blocked;
    } t_stat;

    localparam logic [PC_W-1:0] ST_IDLE    = 4'd0;
    localparam logic [PC_W-1:0] ST_MUL_ES  = 4'd1;
    localparam logic [PC_W-1:0] ST_INTEG   = 4'd2;
    localparam logic [PC_W-1:0] ST_CLAMP   = 4'd3;
    localparam logic [PC_W-1:0] ST_SUM_P   = 4'd4;
    localparam logic [PC_W-1:0] ST_SUM_I   = 4'd5;
    localparam logic [PC_W-1:0] ST_DWAIT   = 4'd6;
    localparam logic [PC_W-1:0] ST_DERIV   = 4'd7;
    localparam logic [PC_W-1:0] ST_MUL_KD  = 4'd8;
    localparam logic [PC_W-1:0] ST_SUM_D   = 4'd9;
    localparam logic [PC_W-1:0] ST_OUT     = 4'd10;
    localparam logic [PC_W-1:0] ST_RET     = 4'd11;

    function automatic t_cword ucode(input logic [PC_W-1:0] pc);
        t_cword w;
        w = '{op: OP_NONE, mul: MUL_NONE, div_start: 1'b0, jc: JC_NEXT, target: ST_IDLE};
        case (pc)
            ST_IDLE:   begin w.op = OP_LOAD; w.jc = JC_IN_WAIT; w.target = ST_IDLE; end
            ST_MUL_ES: begin w.mul = MUL_ERR_STEP; w.div_start = 1'b1; end
            ST_INTEG:  w.op = OP_INTEG;
            ST_CLAMP:  begin w.op = OP_CLAMP; w.mul = MUL_KP; end
            ST_SUM_P:  begin w.op = OP_SUM_LD; w.mul = MUL_KI; end
            ST_SUM_I:  w.op = OP_SUM_ADD;
            ST_DWAIT:  begin w.jc = JC_DIV_WAIT; w.target = ST_DWAIT; end
            ST_DERIV:  w.op = OP_DERIV;
            ST_MUL_KD: w.mul = MUL_KD;
            ST_SUM_D:  w.op = OP_SUM_ADD;
            ST_OUT:    begin w.op = OP_OUT; w.jc = JC_OUT_WAIT; w.target = ST_OUT; end
            ST_RET:    begin w.jc = JC_ALWAYS; w.target = ST_IDLE; end
            default:   begin w.jc = JC_ALWAYS; w.target = ST_IDLE; end
        endcase
        return w;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > S32_MAX_W)
            r = S32_MAX_W[DATA_W-1:0];
        else if (v < S32_MIN_W)
            r = S32_MIN_W[DATA_W-1:0];
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pid_controller_clamped_core.sv =====
// Top level of the clamped PID core: sequencer plus datapath.
//
//  channel | signals                              | beat
//  --------+--------------------------------------+------------------------------
//  in      | i_in_valid/o_in_ready, i_error_in,   | error and step, one per run
//          | i_step_time                          |
//  out     | o_out_valid/i_out_ready, o_drive_out | clipped drive value
//  cfg     | i_cfg_wen, i_cfg_addr, i_cfg_wdata   | single-cycle register write
//
// When the step is non-zero, a beat waits for the serial divider for the
// derivative on its way to the result register; with a zero step the divider
// is not started. The next beat is taken only after the result is written and
// the sequencer is idle again. The shared multiplier serves four products per beat.
// Reset is synchronous, active low; the sequencer returns to its idle step.
// The output register holds one result; a new input beat is taken while it waits.
// For output, the sequencer stalls only to write the next result into a full register.
`default_nettype none

module pid_controller_clamped_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wen,
    input  wire logic [pcc_pkg::ADDR_W-1:0]         i_cfg_addr,
    input  wire logic [pcc_pkg::DATA_W-1:0]         i_cfg_wdata,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic signed [pcc_pkg::DATA_W-1:0]  i_error_in,
    input  wire logic [pcc_pkg::STEP_W-1:0]         i_step_time,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed [pcc_pkg::DATA_W-1:0]       o_drive_out
);
    import pcc_pkg::*;

    t_ctrl w_ctrl;
    t_stat w_stat;

    pcc_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    pcc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .o_stat      (w_stat),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_error_in  (i_error_in),
        .i_step_time (i_step_time),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_drive_out (o_drive_out)
    );

endmodule

`default_nettype wire

// ===== rtl/pcc_div.sv =====
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
`default_nettype none

module pcc_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [pcc_pkg::DVD_W-1:0]   i_dividend,
    input  wire logic [pcc_pkg::STEP_W-1:0]  i_divisor,
    output logic                             o_busy,
    output logic [pcc_pkg::DVD_W-1:0]        o_quot
);
    import pcc_pkg::*;

    logic [CNT_W-1:0]  r_cnt;
    logic [STEP_W-1:0] r_rem;
    logic [STEP_W-1:0] r_dsr;
    logic [DVD_W-1:0]  r_quo;

    logic [STEP_W:0] w_rem_sh;
    logic [STEP_W:0] w_diff;
    logic            w_ge;

    always_comb begin
        w_rem_sh = {r_rem, r_quo[DVD_W-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_dsr});
        w_diff   = w_rem_sh - {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DVD_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_cnt != '0) begin
            // remainder stays below the divisor, so it fits the divisor width
            r_rem <= w_ge ? w_diff[STEP_W-1:0] : w_rem_sh[STEP_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quo;

endmodule

`default_nettype wire

// ===== rtl/pcc_useq.sv =====
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
`default_nettype none

module pcc_useq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire pcc_pkg::t_stat  i_stat,
    output pcc_pkg::t_ctrl       o_ctrl
);
    import pcc_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_cword          w_cw;
    logic            w_stall;
    logic            w_jump;

    always_comb begin
        w_cw    = ucode(r_pc);
        w_stall = 1'b0;
        case (w_cw.jc)
            JC_IN_WAIT:  w_stall = !i_stat.in_valid;
            JC_DIV_WAIT: w_stall = i_stat.div_busy;
            JC_OUT_WAIT: w_stall = i_stat.out_blocked;
            default:     w_stall = 1'b0;
        endcase
        w_jump = w_stall || (w_cw.jc == JC_ALWAYS);
        n_pc   = w_jump ? w_cw.target : r_pc + 1'b1;

        o_ctrl.op        = w_cw.op;
        o_ctrl.mul       = w_cw.mul;
        o_ctrl.div_start = w_cw.div_start;
        o_ctrl.exec      = !w_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pcc_dpath.sv =====
// Datapath: config registers, loop state, shared multiplier, accumulator and output register.
`default_nettype none

module pcc_dpath (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire pcc_pkg::t_ctrl                     i_ctrl,
    output pcc_pkg::t_stat                          o_stat,
    input  wire logic                               i_cfg_wen,
    input  wire logic [pcc_pkg::ADDR_W-1:0]         i_cfg_addr,
    input  wire logic [pcc_pkg::DATA_W-1:0]         i_cfg_wdata,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic signed [pcc_pkg::DATA_W-1:0]  i_error_in,
    input  wire logic [pcc_pkg::STEP_W-1:0]         i_step_time,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed [pcc_pkg::DATA_W-1:0]       o_drive_out
);
    import pcc_pkg::*;

    logic signed [DATA_W-1:0] r_kp, r_ki, r_kd, r_upper, r_lower;
    logic signed [DATA_W-1:0] r_last, r_integ, r_deriv;
    logic signed [DATA_W-1:0] r_err, r_iacc, r_out;
    logic [STEP_W-1:0]        r_step;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_dneg;
    logic                     r_out_valid;

    logic signed [DATA_W:0]     w_mul_a, w_mul_b;
    logic signed [2*DATA_W+1:0] w_mul_full;
    logic signed [SUM_W-1:0]    w_prod_sh;
    logic signed [SUM_W-1:0]    w_integ_sum;
    logic signed [DATA_W:0]     w_err33, w_hi_diff, w_lo_diff, w_ediff;
    logic [DATA_W:0]            w_emag;
    logic signed [DATA_W-1:0]   w_hi, w_lo, w_iclamp;
    logic signed [SUM_W-1:0]    w_qs, w_up_w, w_lo_w, w_clip1, w_clip2;
    logic [DVD_W-1:0]           w_quot;
    logic                       w_div_busy;
    logic                       w_div_start;
    logic                       w_run;

    assign w_run = i_ctrl.exec;

    pcc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({w_emag, {FRAC_W{1'b0}}}),
        .i_divisor  (r_step),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    always_comb begin
        case (i_ctrl.mul)
            MUL_ERR_STEP: begin
                w_mul_a = {r_err[DATA_W-1], r_err};
                w_mul_b = $signed({{(DATA_W+1-STEP_W){1'b0}}, r_step});
            end
            MUL_KP: begin
                w_mul_a = {r_kp[DATA_W-1], r_kp};
                w_mul_b = {r_err[DATA_W-1], r_err};
            end
            MUL_KI: begin
                w_mul_a = {r_ki[DATA_W-1], r_ki};
                w_mul_b = {r_integ[DATA_W-1], r_integ};
            end
            MUL_KD: begin
                w_mul_a = {r_kd[DATA_W-1], r_kd};
                w_mul_b = {r_deriv[DATA_W-1], r_deriv};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
        w_mul_full = w_mul_a * w_mul_b;

        // floor shift of the product back to Q16.16
        w_prod_sh   = {{(SUM_W-PROD_W+FRAC_W){r_prod[PROD_W-1]}}, r_prod[PROD_W-1:FRAC_W]};
        w_integ_sum = {{(SUM_W-DATA_W){r_integ[DATA_W-1]}}, r_integ} + w_prod_sh;

        // anti-windup window
        w_err33   = {r_err[DATA_W-1], r_err};
        w_hi_diff = {r_upper[DATA_W-1], r_upper} - w_err33;
        w_lo_diff = {r_lower[DATA_W-1], r_lower} - w_err33;
        w_hi = (r_upper > r_err)
             ? sat32({{(SUM_W-DATA_W-1){w_hi_diff[DATA_W]}}, w_hi_diff}) : '0;
        w_lo = (r_lower < r_err)
             ? sat32({{(SUM_W-DATA_W-1){w_lo_diff[DATA_W]}}, w_lo_diff}) : '0;
        if (r_iacc > w_hi)
            w_iclamp = w_hi;
        else if (r_iacc < w_lo)
            w_iclamp = w_lo;
        else
            w_iclamp = r_iacc;

        // derivative operands; the widest error change still fits unsigned 33 bits
        w_ediff = w_err33 - {r_last[DATA_W-1], r_last};
        w_emag  = w_ediff[DATA_W] ? (DATA_W+1)'(0) - w_ediff : w_ediff;
        w_div_start = w_run && i_ctrl.div_start && (r_step != '0);
        w_qs = r_dneg ? -$signed({{(SUM_W-DVD_W){1'b0}}, w_quot})
                      : $signed({{(SUM_W-DVD_W){1'b0}}, w_quot});

        // output clip: upper first, then lower wins if the limits cross
        w_up_w  = {{(SUM_W-DATA_W){r_upper[DATA_W-1]}}, r_upper};
        w_lo_w  = {{(SUM_W-DATA_W){r_lower[DATA_W-1]}}, r_lower};
        w_clip1 = (r_sum > w_up_w) ? w_up_w : r_sum;
        w_clip2 = (w_clip1 < w_lo_w) ? w_lo_w : w_clip1;
    end

    // configuration and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= '0;
            r_ki    <= '0;
            r_kd    <= '0;
            r_upper <= UPPER_RST;
            r_lower <= LOWER_RST;
            r_last  <= '0;
            r_integ <= '0;
            r_deriv <= '0;
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_addr)
                    REG_GAIN_PROP:  r_kp    <= i_cfg_wdata;
                    REG_GAIN_INTEG: r_ki    <= i_cfg_wdata;
                    REG_GAIN_DERIV: r_kd    <= i_cfg_wdata;
                    REG_OUT_UPPER:  r_upper <= i_cfg_wdata;
                    REG_OUT_LOWER:  r_lower <= i_cfg_wdata;
                    default:        ;
                endcase
            end
            if (w_run && i_ctrl.op == OP_CLAMP)
                r_integ <= w_iclamp;
            if (w_run && i_ctrl.op == OP_DERIV) begin
                if (r_step != '0)
                    r_deriv <= sat32(w_qs);
                r_last <= r_err;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (w_run) begin
            case (i_ctrl.op)
                OP_LOAD: begin
                    r_err  <= i_error_in;
                    r_step <= i_step_time;
                end
                OP_INTEG:   r_iacc <= sat32(w_integ_sum);
                OP_SUM_LD:  r_sum  <= w_prod_sh;
                OP_SUM_ADD: r_sum  <= r_sum + w_prod_sh;
                OP_OUT:     r_out  <= w_clip2[DATA_W-1:0];
                default:    ;
            endcase
            if (i_ctrl.mul != MUL_NONE)
                r_prod <= w_mul_full[PROD_W-1:0];
        end
        if (w_div_start)
            r_dneg <= w_ediff[DATA_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_run && i_ctrl.op == OP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready         = (i_ctrl.op == OP_LOAD);
    assign o_out_valid        = r_out_valid;
    assign o_drive_out        = r_out;
    assign o_stat.in_valid    = i_in_valid;
    assign o_stat.div_busy    = w_div_busy;
    assign o_stat.out_blocked = r_out_valid && !i_out_ready;

endmodule

`default_nettype wire

// ===== rtl/pcc_chk.sv =====
// Port-level checker for the clamped PID core, bound to the top level.
`default_nettype none

module pcc_chk (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_in_valid,
    input wire logic                               o_in_ready,
    input wire logic                               o_out_valid,
    input wire logic                               i_out_ready,
    input wire logic signed [pcc_pkg::DATA_W-1:0]  o_drive_out
);

    // a pending result neither vanishes nor changes
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_drive_out))
        else $error("result dropped or changed while stalled");

    // an accepted beat keeps the sequencer busy, so ready does not return at once
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready ##1 !o_in_ready)
        else $error("input taken again too soon");

    // a result appears only at the end of a run, never while idle
    a_out_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_ready)
        else $error("result raised outside a run");

    // ready stays up while idle and no beat arrives
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && !i_in_valid |=> o_in_ready)
        else $error("ready dropped without an input beat");

endmodule

bind pid_controller_clamped_core pcc_chk u_pcc_chk (.*);

`default_nettype wire
